[rtl/tcpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcpc_pkg: shared types and constants for the TCP checksum unit
// Holds the classified word item that travels from the front stage through
// the queue to the summing back stage, and the constants and queue widths.
// ---------------------------------------------------------------------------
package tcpc_pkg;

    // Protocol number of TCP, added as the pseudo-header protocol word.
    localparam logic [15:0] PROTO_TCP   = 16'd6;
    // Largest length that fits the 16-bit pseudo-header length field.
    localparam logic [15:0] LEN_MAX     = 16'hffff;
    // Byte count saturates one past the largest length.
    localparam logic [16:0] COUNT_LIMIT = 17'h10000;

    // Queue between front and back stages.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One classified segment word.
    typedef struct packed {
        logic [15:0] word;      // data word, low byte cleared for a final odd byte
        logic        one_byte;  // word carries a single byte
        logic        last;      // final word of the segment
        logic [15:0] pseudo;    // folded sum of address halves and protocol
    } t_item;

endpackage : tcpc_pkg
`default_nettype wire

[rtl/tcp_checksum_with_pseudo_header_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcp_checksum_with_pseudo_header_unit: TCP checksum with IPv4 pseudo-header
// Streams a segment as 16-bit big-endian words and returns one checksum
// transfer per segment.
// ---------------------------------------------------------------------------
// The unit takes one segment word per cycle on the input stream while tready
// is high, with tlast on the final word and tuser set when that final word
// holds only its upper byte. The source and destination addresses on the tdata
// of the final word form the pseudo-header with protocol 6 and the counted
// length. One result transfer follows each final word, which passes the front
// register and the queue; the result is registered in the back stage output
// register. It carries the inverted folded ones'-complement checksum, the
// segment length saturated at 65535, and an overflow flag in tuser for longer
// segments. Sustained rate is one word per cycle while results are taken, set
// by the combinational end-around add in the back stage. While a result waits
// to be taken the back stage holds; the front register and the two-entry queue
// absorb up to three more words before the input stream is stalled.
// ---------------------------------------------------------------------------
module tcp_checksum_with_pseudo_header_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Segment words.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,  // data_word, source_address, destination_address
    input  wire logic        s_axis_tuser,  // single_byte
    input  wire logic        s_axis_tlast,  // last_word
    // Checksum results.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // checksum, segment_length
    output logic             m_axis_tuser   // length_overflow
);

    logic              w_fr_valid;
    logic              w_fr_ready;
    tcpc_pkg::t_item   w_fr_item;
    logic              w_q_valid;
    logic              w_q_ready;
    tcpc_pkg::t_item   w_q_item;

    // Front: accept and classify words.
    tcpc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .o_valid       (w_fr_valid),
        .i_ready       (w_fr_ready),
        .o_item        (w_fr_item)
    );

    // Queue between the two stages.
    tcpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_ready (w_fr_ready),
        .i_item  (w_fr_item),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    // Back: sum, count and produce the checksum.
    tcpc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .o_ready       (w_q_ready),
        .i_item        (w_q_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule : tcp_checksum_with_pseudo_header_unit
`default_nettype wire

[rtl/tcpc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcpc_front: input stage of the TCP checksum unit
// Accepts segment words, masks a trailing odd byte, and pre-sums the address
// halves with the protocol number into one folded pseudo-header word.
// ---------------------------------------------------------------------------
module tcpc_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    // Input stream.
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire logic [79:0]     s_axis_tdata,  // data_word, source_address, destination_address
    input  wire logic            s_axis_tuser,  // single_byte
    input  wire logic            s_axis_tlast,  // last_word
    // Toward the queue.
    output logic                 o_valid,
    input  wire logic            i_ready,
    output tcpc_pkg::t_item      o_item
);

    logic                 r_valid;
    tcpc_pkg::t_item      r_item;
    tcpc_pkg::t_item      n_item;
    logic                 w_accept;
    logic [18:0]          w_addr_sum;
    logic [16:0]          w_fold1;
    logic [15:0]          w_fold2;
    logic [15:0]          w_word;

    assign s_axis_tready = !r_valid || i_ready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_word        = s_axis_tdata[15:0];

    // Pseudo-header partial sum: four address halves plus the protocol word.
    // Five 16-bit terms need three carry bits.
    always_comb begin
        w_addr_sum = {3'b000, s_axis_tdata[47:32]} + {3'b000, s_axis_tdata[31:16]}
                   + {3'b000, s_axis_tdata[79:64]} + {3'b000, s_axis_tdata[63:48]}
                   + {3'b000, tcpc_pkg::PROTO_TCP};
        w_fold1    = {1'b0, w_addr_sum[15:0]} + {14'd0, w_addr_sum[18:16]};
        w_fold2    = w_fold1[15:0] + {15'd0, w_fold1[16]};
    end

    // Classify the word: an odd final byte keeps only the upper byte.
    always_comb begin
        n_item.last     = s_axis_tlast;
        n_item.one_byte = s_axis_tlast && s_axis_tuser;
        n_item.word     = n_item.one_byte ? {w_word[15:8], 8'h00} : w_word;
        n_item.pseudo   = w_fold2;
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule : tcpc_front
`default_nettype wire

[rtl/tcpc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcpc_queue: short item queue between front and back stages
// A small register queue so that the front keeps accepting words while the
// back stage waits on the output.
// ---------------------------------------------------------------------------
module tcpc_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire tcpc_pkg::t_item i_item,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output tcpc_pkg::t_item      o_item
);

    tcpc_pkg::t_item                  r_mem [tcpc_pkg::QUEUE_DEPTH];
    logic [tcpc_pkg::QUEUE_AW-1:0]    r_wr_ptr;
    logic [tcpc_pkg::QUEUE_AW-1:0]    r_rd_ptr;
    logic [tcpc_pkg::QUEUE_CW-1:0]    r_count;
    logic                             w_push;
    logic                             w_pop;

    assign o_ready = (r_count != tcpc_pkg::QUEUE_CW'(tcpc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_item  = r_mem[r_rd_ptr];

    // Pointer and fill bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == tcpc_pkg::QUEUE_AW'(tcpc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == tcpc_pkg::QUEUE_AW'(tcpc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule : tcpc_queue
`default_nettype wire

[rtl/tcpc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcpc_back: summing stage of the TCP checksum unit
// Keeps the ones'-complement running sum and saturating byte count; on the
// final word adds the pseudo-header and length and registers the checksum.
// ---------------------------------------------------------------------------
module tcpc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    // From the queue.
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire tcpc_pkg::t_item i_item,
    // Result stream.
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    output logic [31:0]          m_axis_tdata,  // checksum, segment_length
    output logic                 m_axis_tuser   // length_overflow
);

    logic [15:0] r_sum;
    logic [16:0] r_count;
    logic        r_out_valid;
    logic [15:0] r_checksum;
    logic [15:0] r_length;
    logic        r_overflow;

    logic        w_take;
    logic [16:0] w_count_add;
    logic [16:0] n_count;
    logic        w_ovf;
    logic [15:0] w_len;
    logic [16:0] w_run_add;
    logic [15:0] n_sum;
    logic [17:0] w_fin_add;
    logic [16:0] w_fin_fold1;
    logic [15:0] w_fin_fold2;

    assign o_ready = !r_out_valid || m_axis_tready;
    assign w_take  = i_valid && o_ready;

    // Byte count with saturation one past the 16-bit range.
    always_comb begin
        w_count_add = r_count + (i_item.one_byte ? 17'd1 : 17'd2);
        n_count     = (w_count_add > tcpc_pkg::COUNT_LIMIT) ? tcpc_pkg::COUNT_LIMIT
                                                             : w_count_add;
        w_ovf       = n_count[16];
        w_len       = w_ovf ? tcpc_pkg::LEN_MAX : n_count[15:0];
    end

    // Running end-around add of the data word.
    always_comb begin
        w_run_add = {1'b0, r_sum} + {1'b0, i_item.word};
        n_sum     = w_run_add[15:0] + {15'd0, w_run_add[16]};
    end

    // Final sum: running sum, word, pseudo-header words and length, folded twice.
    always_comb begin
        w_fin_add   = {2'b00, r_sum} + {2'b00, i_item.word}
                    + {2'b00, i_item.pseudo} + {2'b00, w_len};
        w_fin_fold1 = {1'b0, w_fin_add[15:0]} + {15'd0, w_fin_add[17:16]};
        w_fin_fold2 = w_fin_fold1[15:0] + {15'd0, w_fin_fold1[16]};
    end

    // Segment state: cleared after the final word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (w_take) begin
            if (i_item.last) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= n_sum;
                r_count <= n_count;
            end
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= w_take && i_item.last;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_take && i_item.last) begin
            r_checksum <= ~w_fin_fold2;
            r_length   <= w_len;
            r_overflow <= w_ovf;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_length, r_checksum};
    assign m_axis_tuser  = r_overflow;

endmodule : tcpc_back
`default_nettype wire
